// ----- design/lsm_pkg.sv -----
`default_nettype none
package lsm_pkg;

  localparam int MAX_PATTERN_DEF = 32;
  localparam int PAT_REGS        = 4;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;
  localparam int LEN_W           = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_0_7   = 3'd0,
    REG_PAT_8_15  = 3'd1,
    REG_PAT_16_23 = 3'd2,
    REG_PAT_24_31 = 3'd3,
    REG_PAT_LEN   = 3'd4,
    REG_IGN_CASE  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       line_end;
  } lsm_in_t;

  typedef struct packed {
    logic        line_matched;
    logic [31:0] line_number;
  } lsm_out_t;

  typedef logic [PAT_REGS-1:0][CFG_DATA_W-1:0] pat_regs_t;

  function automatic logic [7:0] fold(input logic [7:0] b, input logic ic);
    logic [7:0] r;
    r = b;
    if (ic && b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

  function automatic logic [7:0] pat_byte(input pat_regs_t regs, input logic [4:0] idx);
    return regs[idx[4:3]][{idx[2:0], 3'b000} +: 8];
  endfunction

endpackage
`default_nettype wire

// ----- design/lsm_cell.sv -----
`default_nettype none
module lsm_cell (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       shift,
  input  wire logic [7:0] prev_byte,
  input  wire logic       prev_vld,
  input  wire logic [7:0] pat,
  input  wire logic       en,
  input  wire logic       ign_case,
  output logic      [7:0] byte_o,
  output logic            vld_o,
  output logic            hit
);
  import lsm_pkg::*;

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;
  logic       vld_r;
  logic       vld_nxt;

  always_comb begin
    byte_nxt = byte_r;
    vld_nxt  = vld_r;
    if (shift) begin
      byte_nxt = prev_byte;
      vld_nxt  = prev_vld;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign byte_o = byte_r;
  assign vld_o  = vld_r;
  assign hit    = !en || (vld_r && (fold(byte_r, ign_case) == fold(pat, ign_case)));

endmodule
`default_nettype wire

// ----- design/line_substring_matcher_unit.sv -----
`default_nettype none
// A line's last byte is staged in the window cells, then its result is registered at the output.
// Throughput: one byte per cycle; the input stalls only while a finished result
// waits in the output register and the next byte to be scored ends a line.
// Reset: synchronous, active low; clears the window valid flags, match flag and output
// valid, sets the line counter to 1, the pattern to zero, length to 1 and case folding off.
module line_substring_matcher_unit #(
  parameter int MaxPattern = lsm_pkg::MAX_PATTERN_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire lsm_pkg::lsm_in_t                    in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output lsm_pkg::lsm_out_t                        out_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [lsm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [lsm_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import lsm_pkg::*;

  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MaxPattern);

  pat_regs_t        pat_r;
  pat_regs_t        pat_nxt;
  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] len_nxt;
  logic             ic_r;
  logic             ic_nxt;

  logic             st_vld_r;
  logic             st_vld_nxt;
  logic             st_last_r;
  logic             st_last_nxt;
  logic             found_r;
  logic             found_nxt;
  logic [31:0]      line_cnt_r;
  logic [31:0]      line_cnt_nxt;
  logic             out_vld_r;
  logic             out_vld_nxt;
  lsm_out_t         out_r;
  lsm_out_t         out_nxt;

  logic             in_acc;
  logic             out_free;
  logic             adv;
  logic             matched;
  logic [LEN_W-1:0] len_eff;

  logic [MaxPattern-1:0][7:0] cell_byte;
  logic [MaxPattern-1:0]      cell_vld;
  logic [MaxPattern-1:0]      cell_hit;

  assign cfg_ready = 1'b1;

  always_comb begin
    pat_nxt = pat_r;
    len_nxt = len_r;
    ic_nxt  = ic_r;
    if (cfg_valid) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_PAT_0_7:   pat_nxt[0] = cfg_data;
        REG_PAT_8_15:  pat_nxt[1] = cfg_data;
        REG_PAT_16_23: pat_nxt[2] = cfg_data;
        REG_PAT_24_31: pat_nxt[3] = cfg_data;
        REG_PAT_LEN:   len_nxt    = cfg_data[LEN_W-1:0];
        REG_IGN_CASE:  ic_nxt     = cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign len_eff = (len_r > MaxLen) ? MaxLen : len_r;

  genvar p;
  generate
    for (p = 0; p < MaxPattern; p++) begin : g_cell
      localparam logic [LEN_W-1:0] Pos = LEN_W'(p);
      logic [LEN_W-1:0] idx;
      logic [7:0]       prev_byte;
      logic             prev_vld;

      assign idx = len_eff - LEN_W'(1) - Pos;

      if (p == 0) begin : g_head
        assign prev_byte = in_data.text_byte;
        assign prev_vld  = 1'b1;
      end else begin : g_body
        assign prev_byte = cell_byte[p-1];
        assign prev_vld  = cell_vld[p-1] && !st_last_r;
      end

      lsm_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift     (in_acc),
        .prev_byte (prev_byte),
        .prev_vld  (prev_vld),
        .pat       (pat_byte(pat_r, idx[4:0])),
        .en        (Pos < len_eff),
        .ign_case  (ic_r),
        .byte_o    (cell_byte[p]),
        .vld_o     (cell_vld[p]),
        .hit       (cell_hit[p])
      );
    end
  endgenerate

  assign out_free = !out_vld_r || out_ready;
  assign adv      = st_vld_r && (!st_last_r || out_free);
  assign in_ready = !st_vld_r || adv;
  assign in_acc   = in_valid && in_ready;
  assign matched  = found_r || (&cell_hit);

  always_comb begin
    st_vld_nxt   = st_vld_r;
    st_last_nxt  = st_last_r;
    found_nxt    = found_r;
    line_cnt_nxt = line_cnt_r;
    out_vld_nxt  = out_vld_r;
    out_nxt      = out_r;
    if (out_vld_r && out_ready) begin
      out_vld_nxt = 1'b0;
    end
    if (adv) begin
      st_vld_nxt = 1'b0;
      if (st_last_r) begin
        found_nxt            = 1'b0;
        out_vld_nxt          = 1'b1;
        out_nxt.line_matched = matched;
        out_nxt.line_number  = line_cnt_r;
        if (line_cnt_r != '1) begin
          line_cnt_nxt = line_cnt_r + 32'd1;
        end
      end else begin
        found_nxt = matched;
      end
    end
    if (in_acc) begin
      st_vld_nxt  = 1'b1;
      st_last_nxt = in_data.line_end;
    end
  end

  always_ff @(posedge clk) begin
    out_r       <= out_nxt;
    st_last_r   <= st_last_nxt;
    if (!rst_n) begin
      pat_r      <= '0;
      len_r      <= LEN_W'(1);
      ic_r       <= 1'b0;
      st_vld_r   <= 1'b0;
      found_r    <= 1'b0;
      line_cnt_r <= 32'd1;
      out_vld_r  <= 1'b0;
    end else begin
      pat_r      <= pat_nxt;
      len_r      <= len_nxt;
      ic_r       <= ic_nxt;
      st_vld_r   <= st_vld_nxt;
      found_r    <= found_nxt;
      line_cnt_r <= line_cnt_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire
